[rtl/core/cbgd_pkg.sv]
// shared types, constants and the centroid lookup for the codebook group dot product
`timescale 1ns / 1ps
package cbgd_pkg;

  localparam int NUM_LANES     = 4;
  localparam int ACT_W         = 8;
  localparam int CODE_W        = 4;
  localparam int CENT_W        = 8;
  localparam int TABLE_ENTRIES = 16;
  localparam int TABLE_W       = TABLE_ENTRIES * CENT_W;
  localparam int PROD_W        = ACT_W + CENT_W;
  localparam int PSUM_W        = PROD_W + 2;
  localparam int SUM_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_WIDTH_MODE = 2'd0,
    REG_TABLE_LOW       = 2'd1,
    REG_TABLE_HIGH      = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_2BIT = 1'b0,
    MODE_4BIT = 1'b1
  } code_mode_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  // control of the product stage as seen by the merge stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  function automatic logic signed [CENT_W-1:0] centroid_at(
    input logic [TABLE_W-1:0] tbl,
    input logic [CODE_W-1:0]  code
  );
    return tbl[code*CENT_W +: CENT_W];
  endfunction

endpackage

[rtl/core/cbgd_lane.sv]
// one lane: centroid lookup and signed multiply with the activation, registered
`timescale 1ns / 1ps
module cbgd_lane (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic [cbgd_pkg::CODE_W-1:0]           code,
  input  logic signed [cbgd_pkg::ACT_W-1:0]     act,
  input  logic [cbgd_pkg::TABLE_W-1:0]          centroid_table,
  output cbgd_pkg::prod_t                       prod_r
);

  logic signed [cbgd_pkg::CENT_W-1:0] centroid;
  cbgd_pkg::prod_t                    prod_nxt;

  always_comb begin
    centroid = cbgd_pkg::centroid_at(centroid_table, code);
    prod_nxt = cbgd_pkg::PROD_W'(centroid) * cbgd_pkg::PROD_W'(act);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

[rtl/core/cbgd_merge.sv]
// merge stage: adds the lane products into the running sum and holds the result register
`timescale 1ns / 1ps
module cbgd_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cbgd_pkg::stage_ctl_t                   s1,
  input  cbgd_pkg::prod_t [cbgd_pkg::NUM_LANES-1:0] prods,
  output logic                                   s1_take,
  output logic                                   out_valid_r,
  input  logic                                   out_ready,
  output logic [cbgd_pkg::SUM_W-1:0]             out_data_r
);

  logic [cbgd_pkg::SUM_W-1:0]          sum_r, sum_nxt;
  logic                                out_valid_nxt;
  logic signed [cbgd_pkg::PSUM_W-1:0]  lane_sum;
  logic [cbgd_pkg::SUM_W-1:0]          acc;
  logic                                emit;

  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < cbgd_pkg::NUM_LANES; k++) begin
      lane_sum = lane_sum + cbgd_pkg::PSUM_W'(prods[k]);
    end
    acc = sum_r + cbgd_pkg::SUM_W'(lane_sum);
  end

  // a non-last item never needs the result register
  always_comb begin
    s1_take = s1.valid && (!s1.last || !out_valid_r || out_ready);
    emit    = s1_take && s1.last;
    sum_nxt = sum_r;
    if (s1_take) begin
      sum_nxt = s1.last ? '0 : acc;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= acc;
    end
  end

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> sum_r == '0)
    else $error("running sum not cleared after group end");

  a_emit_value: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_data_r == $past(acc))
    else $error("group sum not captured");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("result valid without a group end");

endmodule

[rtl/core/codebook_int8_group_dot.sv]
// top level: config registers, code unpacking, four product lanes and the merge stage
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tdata packed_byte, act_0..act_3; tlast last_in_group
//  out_    | out | out_tvalid / out_tready| tdata group_sum
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle while no group end waits on a stalled result: four lanes multiply in parallel
// into registered products, and the merge stage adds them and registers each group sum in its result register.
// synchronous active-low reset clears the running sum, config registers and valid flags.
// a stalled result holds only an item that ends a group; items behind it wait, other items keep flowing.
`timescale 1ns / 1ps
module codebook_int8_group_dot (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [39:0]                         in_tdata,   // packed_byte, act_0, act_1, act_2, act_3
  input  logic                                in_tlast,   // last_in_group
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // group_sum
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbgd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbgd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                              mode_r;
  logic [cbgd_pkg::CFG_DATA_W-1:0]   table_low_r, table_high_r;
  logic [cbgd_pkg::TABLE_W-1:0]      centroid_table;
  cbgd_pkg::stage_ctl_t              s1_r, s1_nxt;
  logic                              s1_take;
  logic                              load;
  logic [7:0]                        packed_byte;
  logic [cbgd_pkg::CODE_W-1:0]       codes [cbgd_pkg::NUM_LANES];
  logic signed [cbgd_pkg::ACT_W-1:0] acts  [cbgd_pkg::NUM_LANES];
  cbgd_pkg::prod_t [cbgd_pkg::NUM_LANES-1:0] prods;

  assign cfg_ready      = 1'b1;
  assign centroid_table = {table_high_r, table_low_r};
  assign packed_byte    = in_tdata[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= cbgd_pkg::MODE_2BIT;
      table_low_r  <= '0;
      table_high_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cbgd_pkg::REG_CODE_WIDTH_MODE: mode_r       <= cfg_data[0];
        cbgd_pkg::REG_TABLE_LOW:       table_low_r  <= cfg_data;
        cbgd_pkg::REG_TABLE_HIGH:      table_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack codes; in 4-bit mode the upper two lanes see a zero activation
  always_comb begin
    for (int k = 0; k < cbgd_pkg::NUM_LANES; k++) begin
      if (mode_r == cbgd_pkg::MODE_4BIT) begin
        codes[k] = (k < 2) ? packed_byte[(k & 1)*4 +: 4] : '0;
        acts[k]  = (k < 2) ? in_tdata[8 + k*8 +: 8] : '0;
      end else begin
        codes[k] = {2'b00, packed_byte[k*2 +: 2]};
        acts[k]  = in_tdata[8 + k*8 +: 8];
      end
    end
  end

  assign in_tready = !s1_r.valid || s1_take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    s1_nxt = s1_r;
    if (load) begin
      s1_nxt.valid = 1'b1;
      s1_nxt.last  = in_tlast;
    end else if (s1_take) begin
      s1_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  for (genvar g = 0; g < cbgd_pkg::NUM_LANES; g++) begin : g_lane
    cbgd_lane u_lane (
      .clk            (clk),
      .load           (load),
      .code           (codes[g]),
      .act            (acts[g]),
      .centroid_table (centroid_table),
      .prod_r         (prods[g])
    );
  end

  cbgd_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1          (s1_r),
    .prods       (prods),
    .s1_take     (s1_take),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .out_data_r  (out_tdata)
  );

endmodule
